// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types, protocol constants and the identification ROM shared by the serial
// frame responder modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam logic [7:0] MAGIC_0        = 8'h56;
   localparam logic [7:0] MAGIC_1        = 8'h41;
   localparam logic [7:0] MAGIC_2        = 8'h44;
   localparam logic [7:0] MAGIC_3        = 8'h31;
   localparam logic [7:0] PROTO_VERSION  = 8'h01;
   localparam logic [7:0] OP_PING        = 8'h01;
   localparam logic [7:0] OP_IDENT       = 8'h02;
   localparam logic [7:0] OP_ERROR_REPLY = 8'hFF;
   localparam logic [7:0] OP_REPLY_FLAG  = 8'h80;
   localparam logic [7:0] ERROR_MARK     = 8'h01;
   localparam logic [7:0] PONG_FIRST     = 8'h01;

   localparam int HEADER_LEN  = 8;
   localparam int ERROR_LEN   = 2;
   localparam int PONG_LEN    = 4;
   localparam int ROM_SIZE    = 56;
   localparam int ROM_ADDR_W  = 6;
   localparam int FRAME_IDX_W = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef enum logic [1:0] {
      CMD_PONG,
      CMD_IDENT,
      CMD_ERROR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   opcode;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] id_rom_byte(input logic [ROM_ADDR_W-1:0] addr);
      logic [7:0] data;
      unique case (addr)
         6'd0:  data = 8'h76;
         6'd1:  data = 8'h69;
         6'd2:  data = 8'h74;
         6'd3:  data = 8'h61;
         6'd4:  data = 8'h2D;
         6'd5:  data = 8'h61;
         6'd6:  data = 8'h64;
         6'd7:  data = 8'h62;
         6'd8:  data = 8'h64;
         6'd9:  data = 8'h2F;
         6'd10: data = 8'h30;
         6'd11: data = 8'h2E;
         6'd12: data = 8'h32;
         6'd13: data = 8'h20;
         6'd14: data = 8'h75;
         6'd15: data = 8'h73;
         6'd16: data = 8'h62;
         6'd17: data = 8'h20;
         6'd18: data = 8'h72;
         6'd19: data = 8'h65;
         6'd20: data = 8'h73;
         6'd21: data = 8'h74;
         6'd22: data = 8'h72;
         6'd23: data = 8'h69;
         6'd24: data = 8'h63;
         6'd25: data = 8'h74;
         6'd26: data = 8'h65;
         6'd27: data = 8'h64;
         default: data = 8'h00;
      endcase
      return data;
   endfunction

endpackage

// File: rtl/sfr_parser.sv
// ----------------------------------------------------------------------------
// sfr_parser
// Front end: hunts for the frame magic, gathers the header, skips the
// payload and pushes one reply command per finished request.
// ----------------------------------------------------------------------------
module sfr_parser
   import sfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] byte_data,
   output logic       cmd_push,
   output cmd_type    cmd_data
);

   localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

   typedef enum logic [2:0] {
      HDR_V,
      HDR_A,
      HDR_D,
      HDR_1,
      HDR_VER,
      HDR_OP,
      HDR_LEN_LO,
      HDR_LEN_HI
   } hdr_state_type;

   hdr_state_type    state_ff, state_in;
   logic             in_payload_ff, in_payload_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic [7:0]       version_ff, version_in;
   logic [7:0]       opcode_ff, opcode_in;
   logic [7:0]       len_lo_ff, len_lo_in;
   logic [15:0]      length;
   logic             push;
   cmd_type          cmd;

   function automatic cmd_type classify(input logic [7:0] op);
      cmd_type c;
      c.opcode = op;
      if (op == OP_PING) begin
         c.kind = CMD_PONG;
      end else if (op == OP_IDENT) begin
         c.kind = CMD_IDENT;
      end else begin
         c.kind = CMD_ERROR;
      end
      return c;
   endfunction

   assign length = {byte_data, len_lo_ff};

   always_comb begin
      state_in      = state_ff;
      in_payload_in = in_payload_ff;
      left_in       = left_ff;
      version_in    = version_ff;
      opcode_in     = opcode_ff;
      len_lo_in     = len_lo_ff;
      push          = 1'b0;
      cmd           = classify(opcode_ff);
      if (byte_valid) begin
         if (in_payload_ff) begin
            left_in = left_ff - LEN_W'(1);
            if (left_ff == LEN_W'(1)) begin
               in_payload_in = 1'b0;
               push          = 1'b1;
            end
         end else begin
            unique case (state_ff)
               HDR_V, HDR_A, HDR_D, HDR_1: begin
                  if ((state_ff == HDR_V && byte_data == MAGIC_0) ||
                      (state_ff == HDR_A && byte_data == MAGIC_1) ||
                      (state_ff == HDR_D && byte_data == MAGIC_2) ||
                      (state_ff == HDR_1 && byte_data == MAGIC_3)) begin
                     state_in = hdr_state_type'(state_ff + 3'd1);
                  end else begin
                     state_in = (byte_data == MAGIC_0) ? HDR_A : HDR_V;
                  end
               end
               HDR_VER: begin
                  version_in = byte_data;
                  state_in   = HDR_OP;
               end
               HDR_OP: begin
                  opcode_in = byte_data;
                  state_in  = HDR_LEN_LO;
               end
               HDR_LEN_LO: begin
                  len_lo_in = byte_data;
                  state_in  = HDR_LEN_HI;
               end
               HDR_LEN_HI: begin
                  state_in = HDR_V;
                  if (version_ff != PROTO_VERSION || length > 16'(MAX_PAYLOAD)) begin
                     push        = 1'b1;
                     cmd.kind    = CMD_ERROR;
                  end else if (length == 16'd0) begin
                     push = 1'b1;
                  end else begin
                     left_in       = length[LEN_W-1:0];
                     in_payload_in = 1'b1;
                  end
               end
               default: state_in = HDR_V;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= HDR_V;
         in_payload_ff <= 1'b0;
         left_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         in_payload_ff <= in_payload_in;
         left_ff       <= left_in;
      end
      version_ff <= version_in;
      opcode_ff  <= opcode_in;
      len_lo_ff  <= len_lo_in;
   end

   assign cmd_push = push;
   assign cmd_data = cmd;

endmodule

// File: rtl/sfr_cmd_queue.sv
// ----------------------------------------------------------------------------
// sfr_cmd_queue
// Short FIFO of reply commands between the parser and the framer.
// ----------------------------------------------------------------------------
module sfr_cmd_queue
   import sfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_data,
   input  logic             pop,
   output cmd_type          head,
   output queue_status_type status
);

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_IDX_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_IDX_W'(1);
         end
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/sfr_framer.sv
// ----------------------------------------------------------------------------
// sfr_framer
// Back end: takes one reply command at a time and streams its frame, one
// byte per beat, through a registered output stage.
// ----------------------------------------------------------------------------
module sfr_framer
   import sfr_pkg::*;
#(
   parameter int ID_STRING_LEN = 28
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd_head,
   input  queue_status_type qstat,
   output logic             cmd_pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_byte,
   output logic             out_last
);

   localparam logic [15:0] ID_LEN16 = 16'(ID_STRING_LEN);

   logic                   busy_ff, busy_in;
   cmd_type                cmd_ff;
   logic [FRAME_IDX_W-1:0] idx_ff, idx_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             byte_ff;
   logic                   last_ff;
   logic                   out_free, pop, emit, is_last;
   logic [15:0]            pay_len;
   logic [7:0]             reply_op;
   logic [7:0]             cur_byte;
   logic [FRAME_IDX_W-1:0] last_idx, pay_idx;

   always_comb begin
      unique case (cmd_ff.kind)
         CMD_PONG: begin
            pay_len  = 16'(PONG_LEN);
            reply_op = OP_PING | OP_REPLY_FLAG;
         end
         CMD_IDENT: begin
            pay_len  = ID_LEN16;
            reply_op = OP_IDENT | OP_REPLY_FLAG;
         end
         default: begin
            pay_len  = 16'(ERROR_LEN);
            reply_op = OP_ERROR_REPLY;
         end
      endcase
   end

   assign last_idx = FRAME_IDX_W'(pay_len + 16'(HEADER_LEN - 1));
   assign pay_idx  = idx_ff - FRAME_IDX_W'(HEADER_LEN);
   assign is_last  = (idx_ff == last_idx);

   always_comb begin
      unique case (idx_ff)
         FRAME_IDX_W'(0): cur_byte = MAGIC_0;
         FRAME_IDX_W'(1): cur_byte = MAGIC_1;
         FRAME_IDX_W'(2): cur_byte = MAGIC_2;
         FRAME_IDX_W'(3): cur_byte = MAGIC_3;
         FRAME_IDX_W'(4): cur_byte = PROTO_VERSION;
         FRAME_IDX_W'(5): cur_byte = reply_op;
         FRAME_IDX_W'(6): cur_byte = pay_len[7:0];
         FRAME_IDX_W'(7): cur_byte = pay_len[15:8];
         default: begin
            unique case (cmd_ff.kind)
               CMD_PONG:  cur_byte = (pay_idx == '0) ? PONG_FIRST : 8'h00;
               CMD_IDENT: cur_byte = id_rom_byte(pay_idx);
               default:   cur_byte = (pay_idx == '0) ? cmd_ff.opcode : ERROR_MARK;
            endcase
         end
      endcase
   end

   assign out_free = !valid_ff || out_ready;
   assign pop      = !busy_ff && !qstat.empty;
   assign emit     = busy_ff && out_free;

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && !out_ready;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (emit) begin
         idx_in   = idx_ff + FRAME_IDX_W'(1);
         valid_in = 1'b1;
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      if (pop) begin
         cmd_ff <= cmd_head;
      end
      if (emit) begin
         byte_ff <= cur_byte;
         last_ff <= is_last;
      end
   end

   assign cmd_pop   = pop;
   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

// File: rtl/serial_frame_responder.sv
// ----------------------------------------------------------------------------
// serial_frame_responder
// Parses request frames from a received byte stream and answers each with a
// reply frame.
// ----------------------------------------------------------------------------
// The parser takes one received byte per cycle and queues a reply command
// when a request completes; up to four replies may wait in the command queue,
// and req_ready drops only while it is full. The framer sends one reply byte
// per cycle while rsp_ready is high, from a registered output stage, and it
// pauses between frames to load the next command. A reply is 10 bytes for
// an error, 12 for a pong and 8 + ID_STRING_LEN for the identification string.
module serial_frame_responder
   import sfr_pkg::*;
#(
   parameter int MAX_PAYLOAD   = 1024,
   parameter int ID_STRING_LEN = 28
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_tx_last
);

   logic             cmd_push;
   logic             cmd_pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   queue_status_type qstat;

   assign req_ready = !qstat.full;

   sfr_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_valid(req_valid && req_ready),
      .byte_data (req_rx_byte),
      .cmd_push  (cmd_push),
      .cmd_data  (push_cmd)
   );

   sfr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_data(push_cmd),
      .pop      (cmd_pop),
      .head     (head_cmd),
      .status   (qstat)
   );

   sfr_framer #(
      .ID_STRING_LEN(ID_STRING_LEN)
   ) u_framer (
      .clock    (clock),
      .reset    (reset),
      .cmd_head (head_cmd),
      .qstat    (qstat),
      .cmd_pop  (cmd_pop),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_byte (rsp_tx_byte),
      .out_last (rsp_tx_last)
   );

   assert property (@(posedge clock) disable iff (reset) cmd_push |-> !qstat.full)
      else $error("command pushed into full queue");

   assert property (@(posedge clock) disable iff (reset) cmd_pop |-> !qstat.empty)
      else $error("command popped from empty queue");

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response beat valid right after reset");

endmodule
